@@ rtl/msrc_pkg.sv @@
// Package for the motor speed ramp controller.
// Holds the shared constants, command codes, config indexes and the control struct.
// No dependencies.
package msrc_pkg;

    // Widths of the config registers and payload fields
    localparam int SPEED_W = 10;
    localparam int STEP_W  = 8;
    localparam int REFR_W  = 16;
    localparam int INTEN_W = 8;
    localparam int NOW_W   = 32;
    localparam int DRIVE_W = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int PCT_W   = 7;
    localparam int PROD_W  = SPEED_W + PCT_W;

    // Default for the time compare width
    localparam int DEF_TIME_BITS = 32;

    // Fixed levels
    localparam logic [SPEED_W-1:0] START_SPEED = 10'd60;
    localparam logic [SPEED_W-1:0] SPEED_MAX  = 10'd1023;
    localparam logic [SPEED_W-1:0] BRAKE_FULL = 10'd1023;
    localparam logic [DRIVE_W-1:0] DRIVE_FULL = 11'd1024;
    localparam logic [PCT_W-1:0]   PCT_MAX    = 7'd100;

    // Near-target test: floor(speed*100/target) > 80  <=>  speed*100 >= 81*target
    localparam logic [PROD_W-1:0]  PCT_SCALE  = 17'd100;
    localparam logic [PROD_W-1:0]  NEAR_RATIO = 17'd81;

    // Divide by 100 through a reciprocal; exact for products below 2^24/84
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_W     = 18;
    localparam logic [RECIP_W-1:0] RECIP_K = 18'd167773;

    // Config reset values
    localparam logic [SPEED_W-1:0] RST_SPEED_LIMIT = 10'd1023;
    localparam logic [STEP_W-1:0]  RST_STEP_SIZE   = 8'd10;
    localparam logic [REFR_W-1:0]  RST_REFRESH_MS  = 16'd100;

    // Config register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPEED_LIMIT = 2'd0,
        CFG_STEP_SIZE   = 2'd1,
        CFG_REFRESH_MS  = 2'd2,
        CFG_REVERSE     = 2'd3
    } cfg_index_t;

    // User command codes
    typedef enum logic [1:0] {
        CMD_COAST = 2'd0,
        CMD_ACCEL = 2'd1,
        CMD_HALT  = 2'd2,
        CMD_OTHER = 2'd3
    } motor_cmd_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;    // capture input beat and form limit*percent
        logic div_en;  // reciprocal multiply: target = product / 100
        logic cmp_en;  // target and near-target compares
        logic commit;  // update state and load the result register
    } msrc_cmd_t;

endpackage

@@ rtl/motor_speed_ramp_controller.sv @@
// Motor speed ramp controller: top level.
// Joins the sequencer msrc_ctrl and the datapath msrc_dp; depends on msrc_pkg.
//
// Each input beat is a user command sample or a disable event and yields exactly one
// result beat (drive level, brake level, speed, applied flag). On the way from acceptance
// to a committed result, the accept cycle forms limit x percent, then S_DIV divides by 100
// (reciprocal multiply), S_CMP does the near-target compare and S_UPD the state update,
// which waits while a result is held and out_ready is low. The block works on one item
// at a time; in_ready is high again the cycle after the update, and the result register
// lets the next item be accepted while a result waits, though never before the last one
// is committed. Config writes through cfg_we/cfg_index/cfg_wdata take effect at once and
// should only be issued while no item is in flight. No clearing pass after reset.
module motor_speed_ramp_controller
    import msrc_pkg::*;
#(
    parameter int TIME_BITS = DEF_TIME_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  kind,
    input  logic [1:0]            command,
    input  logic [INTEN_W-1:0]    intensity,
    input  logic [NOW_W-1:0]      now_ms,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [DRIVE_W-1:0]    drive_level,
    output logic [SPEED_W-1:0]    brake_pwm,
    output logic [SPEED_W-1:0]    speed,
    output logic                  applied
);

    msrc_cmd_t cmd;

    // Sequencer
    msrc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // Datapath
    msrc_dp #(
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .kind        (kind),
        .command     (command),
        .intensity   (intensity),
        .now_ms      (now_ms),
        .drive_level (drive_level),
        .brake_pwm   (brake_pwm),
        .speed       (speed),
        .applied     (applied)
    );

endmodule

@@ rtl/msrc_ctrl.sv @@
// Sequencer of the motor speed ramp controller.
// Steps one beat through divide, compare and update; owns the output valid.
// Depends on msrc_pkg.
module msrc_ctrl
    import msrc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output msrc_cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_CMP,
        S_UPD
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   commit;

    // Result slot is free or being emptied this cycle
    assign commit   = (state_reg == S_UPD) && (!out_valid_reg || out_ready);
    assign in_ready = (state_reg == S_IDLE);

    assign cmd.load   = in_valid && in_ready;
    assign cmd.div_en = (state_reg == S_DIV);
    assign cmd.cmp_en = (state_reg == S_CMP);
    assign cmd.commit = commit;

    assign out_valid = out_valid_reg;

    // Next state
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                if (commit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // An accepted beat reaches the update step after passing through S_DIV and S_CMP
    a_accept_to_upd: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> ##2 (state_reg == S_UPD))
        else $error("accepted beat did not reach update step");

    // A commit always presents a result next cycle
    a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> out_valid_reg)
        else $error("commit without result valid");

    // A new result only appears after an update step
    a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_UPD))
        else $error("result valid rose outside update step");

endmodule

@@ rtl/msrc_dp.sv @@
// Datapath of the motor speed ramp controller.
// Config registers, held command state, target divide, ramp step and result register.
// Depends on msrc_pkg.
module msrc_dp
    import msrc_pkg::*;
#(
    parameter int TIME_BITS = DEF_TIME_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  msrc_cmd_t             cmd,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  kind,
    input  logic [1:0]            command,
    input  logic [INTEN_W-1:0]    intensity,
    input  logic [NOW_W-1:0]      now_ms,
    output logic [DRIVE_W-1:0]    drive_level,
    output logic [SPEED_W-1:0]    brake_pwm,
    output logic [SPEED_W-1:0]    speed,
    output logic                  applied
);

    localparam int RPROD_W = PROD_W + RECIP_W;

    // Config registers
    logic [SPEED_W-1:0] speed_limit_reg;
    logic [STEP_W-1:0]  step_size_reg;
    logic [REFR_W-1:0]  refresh_ms_reg;
    logic               reverse_reg;

    // Captured beat and pipeline values
    logic                 kind_reg;
    motor_cmd_t           cmd_reg;
    logic [INTEN_W-1:0]   inten_reg;
    logic [TIME_BITS-1:0] now_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [SPEED_W-1:0]   target_reg;
    logic                 below_reg;
    logic                 near_reg;

    // Controller state
    logic [SPEED_W-1:0]   cur_speed_reg,   cur_speed_next;
    logic                 stop_pending_reg, stop_pending_next;
    motor_cmd_t           held_cmd_reg,    held_cmd_next;
    logic [INTEN_W-1:0]   held_inten_reg,  held_inten_next;
    logic [TIME_BITS-1:0] last_ms_reg,     last_ms_next;
    logic [DRIVE_W-1:0]   drive_hold_reg,  drive_hold_next;
    logic                 brake_on_reg,    brake_on_next;

    // Result register
    logic [DRIVE_W-1:0] drive_out_reg;
    logic               brake_out_reg;
    logic [SPEED_W-1:0] speed_out_reg;
    logic               applied_out_reg;

    // Combinational terms
    logic [PCT_W-1:0]     pct;
    logic [RPROD_W-1:0]   recip_prod;
    logic [TIME_BITS-1:0] elapsed;
    logic                 changed;
    logic                 do_apply;
    logic [STEP_W-1:0]    step_amt;
    logic [DRIVE_W-1:0]   up_sum;
    logic [SPEED_W-1:0]   ramp_speed;
    logic [SPEED_W-1:0]   spd_sel;
    logic [SPEED_W-1:0]   spd_clamp;
    logic                 brk_sel;
    logic                 stp_sel;

    // Config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_limit_reg <= RST_SPEED_LIMIT;
            step_size_reg   <= RST_STEP_SIZE;
            refresh_ms_reg  <= RST_REFRESH_MS;
            reverse_reg     <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_SPEED_LIMIT: speed_limit_reg <= cfg_wdata[SPEED_W-1:0];
                CFG_STEP_SIZE:   step_size_reg   <= cfg_wdata[STEP_W-1:0];
                CFG_REFRESH_MS:  refresh_ms_reg  <= cfg_wdata[REFR_W-1:0];
                CFG_REVERSE:     reverse_reg     <= cfg_wdata[0];
                default:         ;
            endcase
        end
    end

    // Percent, saturated at 100
    assign pct = (intensity > INTEN_W'(PCT_MAX)) ? PCT_MAX : intensity[PCT_W-1:0];

    // Target = product / 100 by reciprocal multiply
    assign recip_prod = RPROD_W'(prod_reg) * RPROD_W'(RECIP_K);

    // Input capture and target pipeline
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg  <= kind;
            cmd_reg   <= motor_cmd_t'(command);
            inten_reg <= intensity;
            now_reg   <= now_ms[TIME_BITS-1:0];
            prod_reg  <= PROD_W'(speed_limit_reg) * PROD_W'(pct);
        end
        if (cmd.div_en)
        begin
            target_reg <= recip_prod[RECIP_SHIFT +: SPEED_W];
        end
        if (cmd.cmp_en)
        begin
            below_reg <= (cur_speed_reg < target_reg);
            near_reg  <= (PROD_W'(cur_speed_reg) * PCT_SCALE)
                         >= (PROD_W'(target_reg) * NEAR_RATIO);
        end
    end

    // Update decision
    assign changed  = (cmd_reg != held_cmd_reg) || (inten_reg != held_inten_reg);
    assign elapsed  = now_reg - last_ms_reg;
    assign do_apply = !kind_reg && (changed || (elapsed > TIME_BITS'(refresh_ms_reg)));

    // Ramp step: half step near the target, step down at or above it
    assign step_amt = near_reg ? (step_size_reg >> 1) : step_size_reg;
    assign up_sum   = DRIVE_W'(cur_speed_reg) + DRIVE_W'(step_amt);
    always_comb
    begin
        if (below_reg)
        begin
            ramp_speed = (up_sum > DRIVE_W'(SPEED_MAX)) ? SPEED_MAX : up_sum[SPEED_W-1:0];
        end
        else if (cur_speed_reg > SPEED_W'(step_size_reg))
        begin
            ramp_speed = cur_speed_reg - SPEED_W'(step_size_reg);
        end
        else
        begin
            ramp_speed = '0;
        end
    end

    // Command action
    always_comb
    begin
        spd_sel = cur_speed_reg;
        brk_sel = brake_on_reg;
        stp_sel = stop_pending_reg;
        unique case (cmd_reg)
            CMD_ACCEL:
            begin
                if (stop_pending_reg)
                begin
                    stp_sel = 1'b0;
                    brk_sel = 1'b0;
                    spd_sel = START_SPEED;
                end
                else if (cur_speed_reg < START_SPEED)
                begin
                    spd_sel = START_SPEED;
                end
                else
                begin
                    spd_sel = ramp_speed;
                end
            end
            CMD_COAST:
            begin
                stp_sel = 1'b0;
                brk_sel = 1'b0;
                spd_sel = '0;
            end
            CMD_HALT:
            begin
                stp_sel = 1'b1;
                brk_sel = 1'b1;
                spd_sel = '0;
            end
            CMD_OTHER:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Clamp to the limit
    assign spd_clamp = (spd_sel > speed_limit_reg) ? speed_limit_reg : spd_sel;

    // Next state
    always_comb
    begin
        cur_speed_next    = cur_speed_reg;
        stop_pending_next = stop_pending_reg;
        held_cmd_next     = held_cmd_reg;
        held_inten_next   = held_inten_reg;
        last_ms_next      = last_ms_reg;
        drive_hold_next   = drive_hold_reg;
        brake_on_next     = brake_on_reg;
        if (kind_reg)
        begin
            // disable: drive off, brake released, speed kept
            drive_hold_next   = reverse_reg ? DRIVE_FULL : '0;
            brake_on_next     = 1'b0;
            stop_pending_next = 1'b0;
        end
        else if (do_apply)
        begin
            held_cmd_next     = cmd_reg;
            held_inten_next   = inten_reg;
            last_ms_next      = now_reg;
            stop_pending_next = stp_sel;
            cur_speed_next    = spd_clamp;
            brake_on_next     = (spd_clamp != '0) ? 1'b0 : brk_sel;
            drive_hold_next   = reverse_reg ? (DRIVE_FULL - DRIVE_W'(spd_clamp))
                                            : DRIVE_W'(spd_clamp);
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_speed_reg    <= '0;
            stop_pending_reg <= 1'b0;
            held_cmd_reg     <= CMD_COAST;
            held_inten_reg   <= '0;
            last_ms_reg      <= '0;
            drive_hold_reg   <= '0;
            brake_on_reg     <= 1'b0;
        end
        else if (cmd.commit)
        begin
            cur_speed_reg    <= cur_speed_next;
            stop_pending_reg <= stop_pending_next;
            held_cmd_reg     <= held_cmd_next;
            held_inten_reg   <= held_inten_next;
            last_ms_reg      <= last_ms_next;
            drive_hold_reg   <= drive_hold_next;
            brake_on_reg     <= brake_on_next;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            drive_out_reg   <= drive_hold_next;
            brake_out_reg   <= brake_on_next;
            speed_out_reg   <= cur_speed_next;
            applied_out_reg <= do_apply;
        end
    end

    assign drive_level = drive_out_reg;
    assign brake_pwm   = brake_out_reg ? BRAKE_FULL : '0;
    assign speed       = speed_out_reg;
    assign applied     = applied_out_reg;

    // Speed never exceeds the limit right after an applied update
    a_speed_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && do_apply) |=> (cur_speed_reg <= speed_limit_reg))
        else $error("speed above limit after update");

    // Brake engaged only at standstill
    a_brake_still: assert property (@(posedge clk) disable iff (!rst_n)
        brake_on_reg |-> (cur_speed_reg == '0))
        else $error("brake engaged with nonzero speed");

    // A disable event never counts as an update
    a_disable_noapply: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && kind_reg) |=> !applied_out_reg)
        else $error("disable event flagged as applied");

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps
// Testbench for motor_speed_ramp_controller: command samples and disable events in,
// drive/brake/speed beats out, each checked against an in-line motor state predictor.
// Depends on msrc_pkg and the RTL top level.
module testbench
    import msrc_pkg::*;
();

    localparam int CLK_HALF    = 5;
    localparam int DRAIN_WAIT  = 8;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 67;
    localparam int NEAR_PCT    = 80;

    typedef struct {
        logic                kind;
        motor_cmd_t          command;
        logic [INTEN_W-1:0]  intensity;
        logic [NOW_W-1:0]    now_ms;
    } motor_beat_t;

    typedef struct {
        logic [DRIVE_W-1:0]  drive;
        logic [SPEED_W-1:0]  brake;
        logic [SPEED_W-1:0]  speed;
        logic                applied;
    } motor_out_t;

    // DUT ports, all inputs known from time zero
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  in_valid  = 1'b0;
    logic                  kind      = 1'b0;
    logic [1:0]            command   = '0;
    logic [INTEN_W-1:0]    intensity = '0;
    logic [NOW_W-1:0]      now_ms    = '0;
    logic                  out_ready = 1'b0;
    logic                  in_ready;
    logic                  out_valid;
    logic [DRIVE_W-1:0]    drive_level;
    logic [SPEED_W-1:0]    brake_pwm;
    logic [SPEED_W-1:0]    speed;
    logic                  applied;

    // Predictor copy of the registers and motor state (reset values)
    int unsigned       lim_reg     = RST_SPEED_LIMIT;
    int unsigned       step_reg    = RST_STEP_SIZE;
    int unsigned       refresh_reg = RST_REFRESH_MS;
    int unsigned       rev_reg     = 0;
    int unsigned       cur_speed   = 0;
    int unsigned       target_lvl  = 0;
    logic              stop_armed  = 1'b0;
    motor_cmd_t        held_cmd    = CMD_COAST;
    logic [INTEN_W-1:0] held_inten = '0;
    logic [NOW_W-1:0]  last_ms     = '0;
    int unsigned       drive_lvl   = 0;
    logic              brake_engaged = 1'b0;

    motor_out_t        pending_outputs[$];
    int unsigned       fail_count  = 0;
    int unsigned       cycle_count = 0;
    int unsigned       gap_pct     = 0;
    int unsigned       stall_pct   = 0;

    // Random traffic generator state
    motor_cmd_t        ramp_cmd    = CMD_ACCEL;
    logic [INTEN_W-1:0] ramp_inten = 8'd100;
    logic [NOW_W-1:0]  clock_ms    = '0;

    motor_speed_ramp_controller dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .command     (command),
        .intensity   (intensity),
        .now_ms      (now_ms),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .drive_level (drive_level),
        .brake_pwm   (brake_pwm),
        .speed       (speed),
        .applied     (applied)
    );

    // Clock
    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver backpressure
    always @(negedge clk)
        out_ready <= ($urandom_range(0, 99) >= stall_pct);

    // Advance the motor state by one input beat and return the expected output beat
    function automatic motor_out_t next_motor_outputs(motor_beat_t b);
        motor_out_t       r;
        int unsigned      pct;
        int unsigned      nxt;
        logic [NOW_W-1:0] elapsed;
        logic             changed;
        r.applied = 1'b0;
        if (b.kind)
        begin
            // disable: drive off, brake released, speed and held pair kept
            drive_lvl     = rev_reg ? DRIVE_FULL : 0;
            brake_engaged = 1'b0;
            target_lvl    = 0;
            stop_armed    = 1'b0;
        end
        else
        begin
            changed = (b.command != held_cmd) || (b.intensity != held_inten);
            elapsed = b.now_ms - last_ms;
            if (changed || elapsed > refresh_reg)
            begin
                r.applied  = 1'b1;
                held_cmd   = b.command;
                held_inten = b.intensity;
                case (b.command)
                    CMD_ACCEL:
                    begin
                        if (stop_armed)
                        begin
                            stop_armed    = 1'b0;
                            brake_engaged = 1'b0;
                            cur_speed     = START_SPEED;
                        end
                        else if (cur_speed < START_SPEED)
                            cur_speed = START_SPEED;
                        else
                        begin
                            pct        = (held_inten > PCT_MAX) ? PCT_MAX : held_inten;
                            target_lvl = (lim_reg * pct) / PCT_MAX;
                            if (cur_speed < target_lvl)
                                nxt = ((cur_speed * PCT_MAX) / target_lvl > NEAR_PCT) ?
                                      cur_speed + step_reg / 2 : cur_speed + step_reg;
                            else
                                nxt = (cur_speed > step_reg) ? cur_speed - step_reg : 0;
                            cur_speed = (nxt > SPEED_MAX) ? SPEED_MAX : nxt;
                        end
                    end
                    CMD_COAST:
                    begin
                        stop_armed    = 1'b0;
                        cur_speed     = 0;
                        target_lvl    = 0;
                        brake_engaged = 1'b0;
                    end
                    CMD_HALT:
                    begin
                        stop_armed    = 1'b1;
                        cur_speed     = 0;
                        brake_engaged = 1'b1;
                    end
                    default: ;
                endcase
                // clamp and rewrite the drive line
                if (cur_speed > lim_reg)
                    cur_speed = lim_reg;
                if (cur_speed > 0)
                    brake_engaged = 1'b0;
                drive_lvl = rev_reg ? DRIVE_FULL - cur_speed : cur_speed;
                last_ms   = b.now_ms;
            end
        end
        r.drive = DRIVE_W'(drive_lvl);
        r.brake = brake_engaged ? BRAKE_FULL : '0;
        r.speed = SPEED_W'(cur_speed);
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Result checker
    always @(posedge clk)
    begin
        motor_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_outputs.size() == 0)
            begin
                $error("result beat with nothing expected");
                fail_count++;
            end
            else
            begin
                want = pending_outputs.pop_front();
                check_field("drive_level", want.drive, drive_level);
                check_field("brake_pwm", want.brake, brake_pwm);
                check_field("speed", want.speed, speed);
                check_field("applied", want.applied, applied);
            end
        end
    end

    function automatic motor_beat_t mk_beat(logic k, motor_cmd_t c, int unsigned pct,
                                            logic [NOW_W-1:0] t);
        motor_beat_t b;
        b.kind      = k;
        b.command   = c;
        b.intensity = INTEN_W'(pct);
        b.now_ms    = t;
        return b;
    endfunction

    // Send one input beat, with random gaps before it
    task automatic send_beat(motor_beat_t b);
        @(negedge clk);
        while ($urandom_range(0, 99) < gap_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        kind      = b.kind;
        command   = b.command;
        intensity = b.intensity;
        now_ms    = b.now_ms;
        in_valid  = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        pending_outputs.push_back(next_motor_outputs(b));
    endtask

    // Drop valid and wait until every result is in and the pipe has emptied
    task automatic wait_idle();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_outputs.size() > 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // Write all four registers, block idle
    task automatic load_settings(int unsigned lim, int unsigned step, int unsigned refr,
                                 int unsigned rev);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = CFG_SPEED_LIMIT;
        cfg_wdata = CFG_DATA_W'(lim);
        @(negedge clk);
        cfg_index = CFG_STEP_SIZE;
        cfg_wdata = CFG_DATA_W'(step);
        @(negedge clk);
        cfg_index = CFG_REFRESH_MS;
        cfg_wdata = CFG_DATA_W'(refr);
        @(negedge clk);
        cfg_index = CFG_REVERSE;
        cfg_wdata = CFG_DATA_W'(rev);
        @(negedge clk);
        cfg_we    = 1'b0;
        lim_reg     = lim;
        step_reg    = step;
        refresh_reg = refr;
        rev_reg     = rev;
    endtask

    function automatic int unsigned pick_value(int unsigned lo, int unsigned hi);
        case ($urandom_range(0, 3))
            0:       return lo;
            1:       return hi;
            default: return $urandom_range(lo, hi);
        endcase
    endfunction

    // Special cases at the reset settings
    task automatic test_directed();
        logic [NOW_W-1:0] t;
        send_beat(mk_beat(1'b0, CMD_ACCEL, 100, 1000));   // jump from rest to 60
        send_beat(mk_beat(1'b0, CMD_ACCEL, 100, 1050));   // inside refresh window
        send_beat(mk_beat(1'b0, CMD_ACCEL, 100, 1100));   // exactly refresh: no update
        send_beat(mk_beat(1'b0, CMD_ACCEL, 100, 1101));   // full step
        send_beat(mk_beat(1'b0, CMD_ACCEL, 255, 1102));   // percent above 100
        send_beat(mk_beat(1'b0, CMD_HALT, 255, 1103));    // brake on
        send_beat(mk_beat(1'b0, CMD_ACCEL, 10, 1104));    // release after stop
        // ramp toward a low target: half steps near it
        t = 1104;
        repeat (4)
        begin
            t = t + 101;
            send_beat(mk_beat(1'b0, CMD_ACCEL, 10, t));
        end
        send_beat(mk_beat(1'b0, CMD_ACCEL, 0, t + 1));    // zero target: step down
        send_beat(mk_beat(1'b0, CMD_OTHER, 0, t + 2));
        send_beat(mk_beat(1'b0, CMD_COAST, 0, t + 3));
        send_beat(mk_beat(1'b1, CMD_ACCEL, 100, t + 4));
        // time wrap
        send_beat(mk_beat(1'b0, CMD_HALT, 0, 32'hFFFF_FFF0));
        send_beat(mk_beat(1'b0, CMD_HALT, 0, 32'h0000_0010));
        send_beat(mk_beat(1'b0, CMD_HALT, 0, 32'h0000_0080));
        send_beat(mk_beat(1'b1, CMD_OTHER, 255, 32'hFFFF_FFFF));
        send_beat(mk_beat(1'b0, CMD_ACCEL, 100, 32'h0000_0081));
    endtask

    // Register extremes: tiny limit with reversed drive, then largest step and interval
    task automatic test_register_extremes();
        logic [NOW_W-1:0] t;
        wait_idle();
        load_settings(1, 1, 0, 1);
        t = 32'h100;
        send_beat(mk_beat(1'b0, CMD_ACCEL, 100, t));
        send_beat(mk_beat(1'b0, CMD_ACCEL, 100, t));      // zero elapsed, zero interval
        send_beat(mk_beat(1'b0, CMD_ACCEL, 100, t + 1));
        send_beat(mk_beat(1'b0, CMD_HALT, 100, t + 2));
        send_beat(mk_beat(1'b0, CMD_ACCEL, 100, t + 3));
        send_beat(mk_beat(1'b1, CMD_COAST, 0, t + 4));    // reversed off level
        wait_idle();
        load_settings(1023, 255, 65535, 0);
        t = 32'h10000;
        send_beat(mk_beat(1'b0, CMD_COAST, 0, t));
        send_beat(mk_beat(1'b0, CMD_ACCEL, 0, t + 1));
        t = t + 65537;
        send_beat(mk_beat(1'b0, CMD_ACCEL, 0, t));        // step down saturates at 0
        send_beat(mk_beat(1'b0, CMD_ACCEL, 100, t + 1));
        // ramp past the 10-bit range
        repeat (4)
        begin
            t = t + 65537;
            send_beat(mk_beat(1'b0, CMD_ACCEL, 100, t));
        end
    endtask

    // Mostly held commands with advancing time, plus disables and noise
    task automatic run_traffic(int n);
        motor_beat_t b;
        int unsigned pick;
        repeat (n)
        begin
            pick        = $urandom_range(0, 99);
            b.kind      = 1'b0;
            b.command   = ramp_cmd;
            b.intensity = ramp_inten;
            if (pick < 70)
            begin
                if ($urandom_range(0, 99) < 15)
                begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4, 5: ramp_cmd = CMD_ACCEL;
                        6, 7:             ramp_cmd = CMD_HALT;
                        8:                ramp_cmd = CMD_COAST;
                        default:          ramp_cmd = CMD_OTHER;
                    endcase
                    ramp_inten  = $urandom_range(0, 1) ? INTEN_W'($urandom_range(0, 255)) :
                                                         INTEN_W'($urandom_range(0, 100));
                    b.command   = ramp_cmd;
                    b.intensity = ramp_inten;
                end
                clock_ms = clock_ms + $urandom_range(0, 2 * refresh_reg + 2);
            end
            else if (pick < 85)
            begin
                b.kind      = 1'b1;
                b.command   = motor_cmd_t'($urandom_range(0, 3));
                b.intensity = INTEN_W'($urandom_range(0, 255));
                clock_ms    = clock_ms + $urandom_range(0, 50);
            end
            else if (pick < 95)
            begin
                b.command   = motor_cmd_t'($urandom_range(0, 3));
                b.intensity = INTEN_W'($urandom_range(0, 255));
                clock_ms    = clock_ms + $urandom_range(0, 4 * refresh_reg + 4);
            end
            else
                clock_ms = $urandom();
            b.now_ms = clock_ms;
            send_beat(b);
        end
    endtask

    // Random traffic under one idling pattern, two register settings
    task automatic test_random_traffic(int unsigned gap, int unsigned stall);
        repeat (2)
        begin
            wait_idle();
            load_settings(pick_value(1, 1023), pick_value(1, 255), pick_value(0, 65535),
                          $urandom_range(0, 1));
            gap_pct   = gap;
            stall_pct = stall;
            run_traffic(PHASE_ITEMS);
        end
    endtask

    initial
    begin
        gap_pct   = 16;
        stall_pct = 52;
        clock_ms  = $urandom();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_register_extremes();
        test_random_traffic(16, 52);
        test_random_traffic(52, 16);
        test_random_traffic(0, 0);
        wait_idle();
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
